>>> src/lrca_pkg.sv
package lrca_pkg;

  localparam int COORD_W = 18;
  localparam int VAL_W   = 32;
  localparam int SUM_W   = 48;
  localparam int HIT_W   = 16;
  localparam int RC_W    = 6;
  localparam int CW      = 20;
  localparam int EXT_BITS = 16;
  localparam int CFG_W   = 3;

  localparam int DEF_GRID_COLS = 64;
  localparam int DEF_GRID_ROWS = 64;
  localparam int DEF_FRAC_BITS = 8;

  localparam logic [HIT_W-1:0] HIT_MAX = '1;

  localparam logic [1:0] KIND_POINT   = 2'd0;
  localparam logic [1:0] KIND_SEGMENT = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;
  localparam logic [1:0] KIND_CLEAR   = 2'd3;

  localparam logic [2:0] MODE_FIRST = 3'd0;
  localparam logic [2:0] MODE_LAST  = 3'd1;
  localparam logic [2:0] MODE_MIN   = 3'd2;
  localparam logic [2:0] MODE_MAX   = 3'd3;
  localparam logic [2:0] MODE_MEAN  = 3'd4;

  localparam logic LINE_THIN  = 1'b0;
  localparam logic LINE_THICK = 1'b1;

  localparam logic REG_COMBINE = 1'b0;
  localparam logic REG_LINE    = 1'b1;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [HIT_W-1:0]        hits;
  } cell_entry_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_BRD,
    S_BWR,
    S_TH_DIV,
    S_TH_WAIT,
    S_TH_LOOP,
    S_TH_NEXT,
    S_TK_CHK,
    S_TK_MUL,
    S_TK_DIV1,
    S_TK_WAIT1,
    S_TK_DIV2,
    S_TK_WAIT2,
    S_TK_E1,
    S_TK_MAJ,
    S_TK_E2,
    S_TK_RUN,
    S_RD_RD,
    S_RD_EV,
    S_RD_WAIT
  } state_t;

endpackage

>>> src/lrca_div.sv
module lrca_div #(
  parameter int DVD_W = 48,
  parameter int DVS_W = 19
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] work;
  logic [DVS_W:0]   rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // one quotient bit per cycle, dividend shifts out as quotient shifts in
  assign trial = {rem[DVS_W-1:0], work[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      work <= {work[DVD_W-2:0], ge};
      rem  <= ge ? diff : trial;
    end
  end

endmodule

>>> src/lrca_ram.sv
module lrca_ram #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [ADDR_W-1:0]     rd_addr,
  output lrca_pkg::cell_entry_t rd_data,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  lrca_pkg::cell_entry_t wr_data
);
  import lrca_pkg::*;

  cell_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/line_raster_cell_accumulator.sv
// Points and segments in fixed-point grid units are rasterized into a GRID_COLS x GRID_ROWS
// grid; each covered cell is combined with burn_value and its hit count bumped. One request
// at a time: busy is high from the accepting edge until the work is done. Each in-grid cell
// is a store read, then a combine and write; an off-grid cell is skipped. A thin segment
// that spans more than one cell adds one divide, a thick one two divides and a multiply;
// every divide goes through the shared bit-serial divider. A read in mean mode of a cell
// with more than one hit also divides its sum by the hit count. A clear request, and reset,
// sweep the store one cell per cycle over all GRID_COLS*GRID_ROWS cells (4096 at the
// defaults) with busy high. A read result is on cell_result, hit_total and has_data in the
// one cycle in which done is high; the receiver cannot hold it off.
module line_raster_cell_accumulator #(
  parameter int GRID_COLS = lrca_pkg::DEF_GRID_COLS,
  parameter int GRID_ROWS = lrca_pkg::DEF_GRID_ROWS,
  parameter int FRAC_BITS = lrca_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          kind,
  input  logic signed [lrca_pkg::COORD_W-1:0] x_start,
  input  logic signed [lrca_pkg::COORD_W-1:0] y_start,
  input  logic signed [lrca_pkg::COORD_W-1:0] x_end,
  input  logic signed [lrca_pkg::COORD_W-1:0] y_end,
  input  logic signed [lrca_pkg::VAL_W-1:0]   burn_value,
  input  logic [lrca_pkg::RC_W-1:0]           read_col,
  input  logic [lrca_pkg::RC_W-1:0]           read_row,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [lrca_pkg::CFG_W-1:0]          cfg_data,
  output logic                                done,
  output logic signed [lrca_pkg::VAL_W-1:0]   cell_result,
  output logic [lrca_pkg::HIT_W-1:0]          hit_total,
  output logic                                has_data
);
  import lrca_pkg::*;

  localparam int AW     = COORD_W + 1;
  localparam int AD_W   = AW;
  localparam int ONE_W  = FRAC_BITS + EXT_BITS;
  localparam int PROD_W = AD_W + FRAC_BITS + 1;
  localparam int DVD_W  = (PROD_W + EXT_BITS > SUM_W) ? PROD_W + EXT_BITS : SUM_W;
  localparam int ACC_W  = AW + EXT_BITS + 2;
  localparam int E_W    = ONE_W + 3;
  localparam int STEP_W = AD_W - FRAC_BITS;
  localparam int DEPTH  = GRID_COLS * GRID_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int HALF   = 1 << (FRAC_BITS - 1);

  localparam logic [FRAC_BITS:0] UNIT  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [E_W-1:0]     E_ONE = {{(E_W-ONE_W-1){1'b0}}, 1'b1, {ONE_W{1'b0}}};

  state_t state, state_next;
  state_t ret, ret_next;

  logic [2:0]        combine_mode;
  logic              line_mode;
  logic [ADDR_W-1:0] clr_addr;

  logic [1:0]              kind_q;
  logic signed [AW-1:0]    ax, ay, bx, by;
  logic signed [VAL_W-1:0] val;
  logic [RC_W-1:0]         rcol, rrow;

  logic signed [CW-1:0]    pm, pn, tm, tn;
  logic                    m_is_x, sm_neg, sn_pos, slope_neg, rneg;
  logic [STEP_W-1:0]       steps;
  logic signed [ACC_W-1:0] acc;
  logic [ONE_W:0]          slope;
  logic [ONE_W:0]          dd;
  logic [E_W-1:0]          e;
  logic [PROD_W-1:0]       prod;

  // derived from the captured request
  logic signed [AW-1:0] cax, cay, cbx, cby;
  logic signed [AW:0]   dlx, dly, dl_m, dl_n;
  logic [AD_W-1:0]      adx, ady, ad_m, ad_n;
  logic [FRAC_BITS-1:0] fr_m, fr_n;
  logic signed [AW-1:0] a_n, ca_m, ca_n, cb_m, cb_n;
  logic                 maj_x, cells_eq;
  logic [FRAC_BITS:0]   lead_dist, frn_term;

  logic signed [CW-1:0]    bxp, byp;
  logic                    b_in_grid, r_in_grid;
  logic [ADDR_W-1:0]       baddr, raddr;
  logic signed [CW-1:0]    mc;
  logic signed [ACC_W-1:0] slope_s;
  logic signed [CW-1:0]    pm_step, pn_step;
  logic                    e_gt_one;

  logic                    rd_en, wr_en;
  logic [ADDR_W-1:0]       rd_addr, wr_addr;
  cell_entry_t             rd_data, wr_data;

  logic                    div_start, div_busy, div_done;
  logic [DVD_W-1:0]        div_dividend, div_q;
  logic [AD_W-1:0]         div_divisor;

  logic signed [SUM_W-1:0] cur, v_ext, new_sum;
  logic signed [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0]        sum_mag;
  logic signed [SUM_W:0]   q_mag;
  logic                    rd_divide;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W:0] v);
    logic signed [SUM_W:0] hi;
    logic signed [SUM_W:0] lo;
    hi = $signed({{(SUM_W-VAL_W+2){1'b0}}, {(VAL_W-1){1'b1}}});
    lo = $signed({{(SUM_W-VAL_W+2){1'b1}}, {(VAL_W-1){1'b0}}});
    if (v > hi) begin
      sat32 = hi[VAL_W-1:0];
    end else if (v < lo) begin
      sat32 = lo[VAL_W-1:0];
    end else begin
      sat32 = v[VAL_W-1:0];
    end
  endfunction

  lrca_div #(
    .DVD_W(DVD_W),
    .DVS_W(AD_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(div_q)
  );

  lrca_ram #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  assign busy = (state != S_IDLE);

  // geometry of the captured segment
  always_comb begin
    cax = ax >>> FRAC_BITS;
    cay = ay >>> FRAC_BITS;
    cbx = bx >>> FRAC_BITS;
    cby = by >>> FRAC_BITS;
    dlx = {bx[AW-1], bx} - {ax[AW-1], ax};
    dly = {by[AW-1], by} - {ay[AW-1], ay};
    adx = AD_W'(dlx[AW] ? -dlx : dlx);
    ady = AD_W'(dly[AW] ? -dly : dly);
    maj_x = adx > ady;
    cells_eq = (cax == cbx) && (cay == cby);
    if (maj_x) begin
      dl_m = dlx; dl_n = dly; ad_m = adx; ad_n = ady;
      fr_m = ax[FRAC_BITS-1:0]; fr_n = ay[FRAC_BITS-1:0];
      a_n = ay; ca_m = cax; ca_n = cay; cb_m = cbx; cb_n = cby;
    end else begin
      dl_m = dly; dl_n = dlx; ad_m = ady; ad_n = adx;
      fr_m = ay[FRAC_BITS-1:0]; fr_n = ax[FRAC_BITS-1:0];
      a_n = ax; ca_m = cay; ca_n = cax; cb_m = cby; cb_n = cbx;
    end
    lead_dist = sm_neg ? {1'b0, fr_m} : UNIT - {1'b0, fr_m};
    frn_term  = sn_pos ? {1'b0, fr_n} : UNIT - {1'b0, fr_n};
  end

  always_comb begin
    bxp = m_is_x ? pm : pn;
    byp = m_is_x ? pn : pm;
    b_in_grid = !bxp[CW-1] && (bxp < CW'(GRID_COLS)) && !byp[CW-1] && (byp < CW'(GRID_ROWS));
    baddr = ADDR_W'($unsigned(byp) * GRID_COLS + $unsigned(bxp));
    r_in_grid = (32'(rcol) < GRID_COLS) && (32'(rrow) < GRID_ROWS);
    raddr = ADDR_W'(32'(rrow) * GRID_COLS + 32'(rcol));
    mc = CW'(acc >>> ONE_W);
    slope_s = $signed({{(ACC_W-ONE_W-1){1'b0}}, slope});
    pm_step = sm_neg ? pm - CW'(1) : pm + CW'(1);
    pn_step = sn_pos ? pn + CW'(1) : pn - CW'(1);
    e_gt_one = e > E_ONE;
  end

  // combine the stored cell with the burn value
  always_comb begin
    cur = rd_data.sum;
    v_ext = SUM_W'(val);
    sum_wide = {cur[SUM_W-1], cur} + (SUM_W+1)'(val);
    new_sum = cur;
    if (rd_data.hits == '0) begin
      new_sum = v_ext;
    end else begin
      case (combine_mode)
        MODE_LAST: new_sum = v_ext;
        MODE_MIN: if (v_ext < cur) new_sum = v_ext;
        MODE_MAX: if (v_ext > cur) new_sum = v_ext;
        MODE_MEAN: begin
          if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            new_sum = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
          end else begin
            new_sum = sum_wide[SUM_W-1:0];
          end
        end
        default: new_sum = cur;
      endcase
    end
    sum_mag = cur[SUM_W-1] ? -cur : cur;
    rd_divide = (combine_mode == MODE_MEAN) && (rd_data.hits > HIT_W'(1));
    q_mag = {1'b0, div_q[SUM_W-1:0]};
  end

  // next state
  always_comb begin
    state_next = state;
    ret_next = ret;
    case (state)
      S_CLEAR: if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          case (kind)
            KIND_READ:  state_next = S_RD_RD;
            KIND_CLEAR: state_next = S_CLEAR;
            default:    state_next = S_SETUP;
          endcase
        end
      end
      S_SETUP: begin
        if (kind_q == KIND_POINT || (line_mode == LINE_THIN && cells_eq)) begin
          state_next = S_BRD;
          ret_next = S_IDLE;
        end else if (line_mode == LINE_THIN) begin
          state_next = S_TH_DIV;
        end else begin
          state_next = S_BRD;
          ret_next = S_TK_CHK;
        end
      end
      S_BRD:      state_next = b_in_grid ? S_BWR : ret;
      S_BWR:      state_next = ret;
      S_TH_DIV:   state_next = S_TH_WAIT;
      S_TH_WAIT:  if (div_done) state_next = S_TH_LOOP;
      S_TH_LOOP: begin
        state_next = S_BRD;
        ret_next = S_TH_NEXT;
      end
      S_TH_NEXT:  state_next = (steps == '0) ? S_IDLE : S_TH_LOOP;
      S_TK_CHK:   state_next = (pm == tm && pn == tn) ? S_IDLE : S_TK_MUL;
      S_TK_MUL:   state_next = S_TK_DIV1;
      S_TK_DIV1:  state_next = S_TK_WAIT1;
      S_TK_WAIT1: if (div_done) state_next = S_TK_DIV2;
      S_TK_DIV2:  state_next = S_TK_WAIT2;
      S_TK_WAIT2: if (div_done) state_next = S_TK_E1;
      S_TK_E1: begin
        if (e_gt_one) begin
          state_next = S_BRD;
          ret_next = S_TK_E1;
        end else begin
          state_next = S_TK_MAJ;
        end
      end
      S_TK_MAJ: begin
        if (pm != tm) begin
          state_next = S_BRD;
          ret_next = S_TK_E2;
        end else begin
          state_next = S_TK_RUN;
        end
      end
      S_TK_E2: begin
        if (pm != tm && e_gt_one) begin
          state_next = S_BRD;
          ret_next = S_TK_E2;
        end else begin
          state_next = S_TK_MAJ;
        end
      end
      S_TK_RUN: begin
        if (pn != tn) begin
          state_next = S_BRD;
          ret_next = S_TK_RUN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_RD_RD:   state_next = r_in_grid ? S_RD_EV : S_IDLE;
      S_RD_EV:   state_next = rd_divide ? S_RD_WAIT : S_IDLE;
      S_RD_WAIT: if (div_done) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // store and divider controls
  always_comb begin
    rd_en = 1'b0;
    rd_addr = baddr;
    wr_en = 1'b0;
    wr_addr = baddr;
    wr_data.sum = new_sum;
    wr_data.hits = (rd_data.hits == HIT_MAX) ? rd_data.hits : rd_data.hits + 1'b1;
    div_start = 1'b0;
    div_dividend = '0;
    div_divisor = ad_m;
    case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      S_BRD: rd_en = b_in_grid;
      S_BWR: wr_en = 1'b1;
      S_RD_RD: begin
        rd_en = r_in_grid;
        rd_addr = raddr;
      end
      S_TH_DIV, S_TK_DIV2: begin
        div_start = 1'b1;
        div_dividend = DVD_W'({ad_n, {ONE_W{1'b0}}});
      end
      S_TK_DIV1: begin
        div_start = 1'b1;
        div_dividend = DVD_W'({prod, {EXT_BITS{1'b0}}});
      end
      S_RD_EV: begin
        div_start = rd_divide;
        div_dividend = DVD_W'(sum_mag);
        div_divisor = AD_W'(rd_data.hits);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ret <= S_IDLE;
      clr_addr <= '0;
      done <= 1'b0;
      combine_mode <= MODE_LAST;
      line_mode <= LINE_THICK;
    end else begin
      state <= state_next;
      ret <= ret_next;
      if (state == S_CLEAR) begin
        clr_addr <= (state_next == S_CLEAR) ? clr_addr + 1'b1 : '0;
      end
      done <= ((state == S_RD_RD) && !r_in_grid) ||
              ((state == S_RD_EV) && !rd_divide) ||
              ((state == S_RD_WAIT) && div_done);
      if (cfg_write) begin
        if (cfg_index == REG_COMBINE) begin
          combine_mode <= cfg_data;
        end else begin
          line_mode <= cfg_data[0];
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          kind_q <= kind;
          ax <= {x_start[COORD_W-1], x_start} + AW'(HALF);
          ay <= {y_start[COORD_W-1], y_start} + AW'(HALF);
          bx <= {x_end[COORD_W-1], x_end} + AW'(HALF);
          by <= {y_end[COORD_W-1], y_end} + AW'(HALF);
          val <= burn_value;
          rcol <= read_col;
          rrow <= read_row;
        end
      end
      S_SETUP: begin
        pm <= CW'(ca_m);
        pn <= CW'(ca_n);
        tm <= CW'(cb_m);
        tn <= CW'(cb_n);
        m_is_x <= maj_x;
        sm_neg <= dl_m[AW];
        sn_pos <= !dl_n[AW] && (dl_n != '0);
        slope_neg <= dl_n[AW];
        steps <= STEP_W'(ad_m >> FRAC_BITS);
        acc <= $signed({{2{a_n[AW-1]}}, a_n, {EXT_BITS{1'b0}}});
      end
      S_TH_WAIT: if (div_done) slope <= div_q[ONE_W:0];
      S_TH_LOOP: pn <= mc;
      S_TH_NEXT: begin
        if (steps != '0) begin
          steps <= steps - 1'b1;
          pm <= pm_step;
          acc <= slope_neg ? acc - slope_s : acc + slope_s;
        end
      end
      S_TK_MUL: prod <= PROD_W'(ad_n * lead_dist);
      S_TK_WAIT1: begin
        if (div_done) e <= E_W'({frn_term, {EXT_BITS{1'b0}}}) + E_W'(div_q);
      end
      S_TK_WAIT2: if (div_done) dd <= div_q[ONE_W:0];
      S_TK_E1: begin
        if (e_gt_one) begin
          e <= e - E_ONE;
          pn <= pn_step;
        end
      end
      S_TK_MAJ: begin
        if (pm != tm) begin
          pm <= pm_step;
          e <= e + E_W'(dd);
        end
      end
      S_TK_E2: begin
        if (pm != tm && e_gt_one) begin
          e <= e - E_ONE;
          pn <= pn_step;
        end
      end
      S_TK_RUN: begin
        if (pn != tn) pn <= (pn < tn) ? pn + CW'(1) : pn - CW'(1);
      end
      S_RD_RD: begin
        if (!r_in_grid) begin
          cell_result <= '0;
          hit_total <= '0;
          has_data <= 1'b0;
        end
      end
      S_RD_EV: begin
        rneg <= cur[SUM_W-1];
        hit_total <= rd_data.hits;
        has_data <= (rd_data.hits != '0);
        cell_result <= (rd_data.hits == '0) ? '0 : sat32({cur[SUM_W-1], cur});
      end
      S_RD_WAIT: begin
        if (div_done) cell_result <= sat32(rneg ? -q_mag : q_mag);
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a request is in flight");
  a_wr_src: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_BWR || state == S_CLEAR))
    else $error("store written outside burn or clear");
  a_div_free: assert property (@(posedge clk) disable iff (rst) div_start |-> !div_busy)
    else $error("divider started while busy");
  a_bwr_after_brd: assert property (@(posedge clk) disable iff (rst)
    (state == S_BWR) |-> $past(state == S_BRD))
    else $error("cell write without a preceding read");
  a_burn_hits: assert property (@(posedge clk) disable iff (rst)
    (state == S_BWR) |-> (wr_data.hits != '0))
    else $error("burned cell left with no hits");
`endif

endmodule
